[sv/lcbs_pkg.sv]
package lcbs_pkg;

    // Field widths of the words on the two channels.
    localparam int TB_W     = 20;
    localparam int RATE_W   = 13;
    localparam int BG1_W    = 14;
    localparam int BG2_W    = 12;
    localparam int KB_W     = 5;
    localparam int NB_W     = 8;
    localparam int K1_OUT_W = 14;
    localparam int CRC_W    = 5;
    localparam int ZC_W     = 9;
    localparam int SET_W    = 3;
    localparam int BS_W     = 14;

    // Divider width: numerator b + d - 1 and b + c - 1 both fit 21 bits.
    localparam int DIV_W = 21;

    // Register reset values.
    localparam logic [BG1_W-1:0] MAX_BG1_RESET = 14'd8448;
    localparam logic [BG2_W-1:0] MAX_BG2_RESET = 12'd3840;

    // Base graph selection thresholds.
    localparam logic [TB_W-1:0]   BG2_SMALL_TB   = 20'd292;
    localparam logic [DIV_W-1:0]  BG2_MARGIN     = 21'd16;
    localparam int                RATE_BG2_NUM   = 67 * 1024;
    localparam logic [RATE_W-1:0] RATE_BG2_MAX   = RATE_W'(RATE_BG2_NUM / 100);
    localparam logic [RATE_W-1:0] RATE_BG2_FORCE = 13'd256;
    localparam logic [TB_W-1:0]   TB_LIMIT       = 20'd125000;

    // Segmentation constants.
    localparam logic [BG1_W-1:0] CB_CRC_LEN     = 14'd24;
    localparam logic [CRC_W-1:0] CRC_BITS_MULTI = 5'd24;
    localparam logic [CRC_W-1:0] CRC_BITS_NONE  = 5'd0;
    localparam logic [NB_W-1:0]  NUM_BLOCKS_MAX = 8'd128;

    // Information columns of the base graphs.
    localparam logic [KB_W-1:0] KB_BG1    = 5'd22;
    localparam logic [KB_W-1:0] KB_BG2_10 = 5'd10;
    localparam logic [KB_W-1:0] KB_BG2_9  = 5'd9;
    localparam logic [KB_W-1:0] KB_BG2_8  = 5'd8;
    localparam logic [KB_W-1:0] KB_BG2_6  = 5'd6;
    localparam logic [TB_W-1:0] KB_TB_640 = 20'd640;
    localparam logic [TB_W-1:0] KB_TB_560 = 20'd560;
    localparam logic [TB_W-1:0] KB_TB_192 = 20'd192;

    // Lifting size table, ascending, and the set index of each entry.
    localparam int LIFT_COUNT = 51;
    localparam int LIFT_IDX_W = $clog2(LIFT_COUNT);
    localparam logic [LIFT_IDX_W-1:0] LIFT_LAST = LIFT_IDX_W'(LIFT_COUNT - 1);

    localparam logic [ZC_W-1:0] LIFT_SIZE [LIFT_COUNT] = '{
        9'd2,   9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,
        9'd10,  9'd11,  9'd12,  9'd13,  9'd14,  9'd15,  9'd16,
        9'd18,  9'd20,  9'd22,  9'd24,  9'd26,  9'd28,  9'd30,  9'd32,
        9'd36,  9'd40,  9'd44,  9'd48,  9'd52,  9'd56,  9'd60,  9'd64,
        9'd72,  9'd80,  9'd88,  9'd96,  9'd104, 9'd112, 9'd120, 9'd128,
        9'd144, 9'd160, 9'd176, 9'd192, 9'd208, 9'd224, 9'd240, 9'd256,
        9'd288, 9'd320, 9'd352, 9'd384
    };

    localparam logic [SET_W-1:0] LIFT_SET [LIFT_COUNT] = '{
        3'd0, 3'd1, 3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd4,
        3'd2, 3'd5, 3'd1, 3'd6, 3'd3, 3'd7, 3'd0,
        3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd3, 3'd7, 3'd0,
        3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd3, 3'd7, 3'd0,
        3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd3, 3'd7, 3'd0,
        3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd3, 3'd7, 3'd0,
        3'd4, 3'd2, 3'd5, 3'd1
    };

    // APB register map, word addressed by paddr[2].
    localparam int PADDR_W = 3;
    typedef enum logic
    {
        REG_MAX_BG1 = 1'b0,
        REG_MAX_BG2 = 1'b1
    } lcbs_reg_t;

    // Side information that travels with an item down the pipeline.
    typedef struct packed
    {
        logic [TB_W-1:0] tb_bits;
        logic            bg2;
        logic [KB_W-1:0] kb;
        logic            single;
        logic            size_err;
        logic [NB_W-1:0] c_sat;
    } lcbs_item_t;

    // One result word.
    typedef struct packed
    {
        logic                base_graph;
        logic [NB_W-1:0]     num_blocks;
        logic [K1_OUT_W-1:0] bits_per_block;
        logic [CRC_W-1:0]    crc_bits;
        logic [ZC_W-1:0]     lifting_size;
        logic [SET_W-1:0]    lift_set;
        logic [BS_W-1:0]     block_size;
        logic                size_error;
    } lcbs_result_t;

endpackage

[sv/lcbs_ifs.sv]
// Input channel: one transport block description per word.
interface lcbs_in_if
    import lcbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TB_W-1:0]   tb_bits;
    logic [RATE_W-1:0] rate_q10;

    modport source (output valid, output tb_bits, output rate_q10, input ready);
    modport sink (input valid, input tb_bits, input rate_q10, output ready);
endinterface

// Output channel: one segmentation result per word.
interface lcbs_out_if
    import lcbs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                base_graph;
    logic [NB_W-1:0]     num_blocks;
    logic [K1_OUT_W-1:0] bits_per_block;
    logic [CRC_W-1:0]    crc_bits;
    logic [ZC_W-1:0]     lifting_size;
    logic [SET_W-1:0]    lift_set;
    logic [BS_W-1:0]     block_size;
    logic                size_error;

    modport source (
        output valid, output base_graph, output num_blocks, output bits_per_block,
        output crc_bits, output lifting_size, output lift_set, output block_size,
        output size_error, input ready
    );
    modport sink (
        input valid, input base_graph, input num_blocks, input bits_per_block,
        input crc_bits, input lifting_size, input lift_set, input block_size,
        input size_error, output ready
    );
endinterface

[sv/lcbs_front.sv]
module lcbs_front
    import lcbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [TB_W-1:0]   tb_bits,
    input  logic [RATE_W-1:0] rate_q10,
    input  logic [BG1_W-1:0]  max_bg1,
    input  logic [BG2_W-1:0]  max_bg2,
    output logic              out_valid,
    output logic [DIV_W-1:0]  out_num,
    output logic [DIV_W-1:0]  out_den,
    output lcbs_item_t        out_item
);

    logic             f1_v_reg;
    lcbs_item_t       f1_item_reg;
    lcbs_item_t       f1_item_next;
    logic             f2_v_reg;
    lcbs_item_t       f2_item_reg;
    lcbs_item_t       f2_item_next;
    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] num_next;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W-1:0] den_next;
    logic [BG1_W-1:0] kcb;
    logic             bg2_fits;

    // First stage: base graph, Kb and the oversize flag.
    always_comb
    begin
        bg2_fits = ((DIV_W'(tb_bits) + BG2_MARGIN) <= DIV_W'(max_bg2))
                   && (rate_q10 <= RATE_BG2_MAX);
        f1_item_next          = '0;
        f1_item_next.tb_bits  = tb_bits;
        f1_item_next.bg2      = (tb_bits <= BG2_SMALL_TB) || bg2_fits
                                || (rate_q10 <= RATE_BG2_FORCE);
        f1_item_next.size_err = tb_bits > TB_LIMIT;
        if (!f1_item_next.bg2)
        begin
            f1_item_next.kb = KB_BG1;
        end
        else if (tb_bits > KB_TB_640)
        begin
            f1_item_next.kb = KB_BG2_10;
        end
        else if (tb_bits > KB_TB_560)
        begin
            f1_item_next.kb = KB_BG2_9;
        end
        else if (tb_bits > KB_TB_192)
        begin
            f1_item_next.kb = KB_BG2_8;
        end
        else
        begin
            f1_item_next.kb = KB_BG2_6;
        end
    end

    // Second stage: largest block size, single block test, divider operands.
    // The quotient ceil(b / d) is floor((b + d - 1) / d).
    always_comb
    begin
        kcb = f1_item_reg.bg2 ? BG1_W'(max_bg2) : max_bg1;
        f2_item_next        = f1_item_reg;
        f2_item_next.single = f1_item_reg.tb_bits <= TB_W'(kcb);
        if (kcb > CB_CRC_LEN)
        begin
            den_next = DIV_W'(kcb - CB_CRC_LEN);
            num_next = DIV_W'(f1_item_reg.tb_bits) + den_next - DIV_W'(1);
        end
        else
        begin
            den_next = DIV_W'(1);
            num_next = DIV_W'(f1_item_reg.tb_bits);
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_item_reg <= f1_item_next;
            f2_item_reg <= f2_item_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
        end
    end

    assign out_valid = f2_v_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_item  = f2_item_reg;

endmodule

[sv/lcbs_div.sv]
module lcbs_div
    import lcbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] in_num,
    input  logic [DIV_W-1:0] in_den,
    input  lcbs_item_t       in_item,
    output logic             out_valid,
    output logic [DIV_W-1:0] out_quo,
    output lcbs_item_t       out_item
);

    // Restoring division, one quotient bit per stage. The numerator shifts
    // out of the top of quo while quotient bits shift in at the bottom.
    logic             v_reg    [DIV_W];
    logic [DIV_W-1:0] quo_reg  [DIV_W];
    logic [DIV_W-1:0] den_reg  [DIV_W];
    lcbs_item_t       item_reg [DIV_W];
    logic [DIV_W-1:0] rem_reg  [DIV_W-1];

    logic             cur_v    [DIV_W];
    logic [DIV_W-1:0] cur_quo  [DIV_W];
    logic [DIV_W-1:0] cur_den  [DIV_W];
    lcbs_item_t       cur_item [DIV_W];
    logic [DIV_W-1:0] cur_rem  [DIV_W];

    for (genvar k = 0; k < DIV_W; k++)
    begin : g_step
        logic [DIV_W:0]   trial;
        logic             fits;
        logic [DIV_W-1:0] quo_next;

        // Stage inputs come from the ports or from the previous stage.
        if (k == 0)
        begin : g_first
            assign cur_v[k]    = in_valid;
            assign cur_quo[k]  = in_num;
            assign cur_den[k]  = in_den;
            assign cur_item[k] = in_item;
            assign cur_rem[k]  = '0;
        end
        else
        begin : g_next
            assign cur_v[k]    = v_reg[k-1];
            assign cur_quo[k]  = quo_reg[k-1];
            assign cur_den[k]  = den_reg[k-1];
            assign cur_item[k] = item_reg[k-1];
            assign cur_rem[k]  = rem_reg[k-1];
        end

        // Trial subtraction of the divisor.
        assign trial    = {cur_rem[k], cur_quo[k][DIV_W-1]};
        assign fits     = trial >= {1'b0, cur_den[k]};
        assign quo_next = {cur_quo[k][DIV_W-2:0], fits};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= cur_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= cur_den[k];
                item_reg[k] <= cur_item[k];
            end
        end

        // The remainder is not needed after the last step.
        if (k < DIV_W - 1)
        begin : g_rem
            logic [DIV_W-1:0] rem_next;

            assign rem_next = fits ? DIV_W'(trial - {1'b0, cur_den[k]})
                                   : trial[DIV_W-1:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign out_valid = v_reg[DIV_W-1];
    assign out_quo   = quo_reg[DIV_W-1];
    assign out_item  = item_reg[DIV_W-1];

endmodule

[sv/lcbs_lift.sv]
module lcbs_lift
    import lcbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] in_quo,
    input  lcbs_item_t       in_item,
    output logic             out_valid,
    output lcbs_result_t     out_res
);

    logic                  k_v_reg;
    logic [DIV_W-1:0]      k1_reg;
    logic [DIV_W-1:0]      k1_next;
    lcbs_item_t            k_item_reg;
    logic                  t1_v_reg;
    logic [LIFT_COUNT-1:0] ge_reg;
    logic [LIFT_COUNT-1:0] ge_next;
    logic [K1_OUT_W-1:0]   t1_k1_reg;
    lcbs_item_t            t1_item_reg;
    logic                  t2_v_reg;
    logic [LIFT_IDX_W-1:0] idx_reg;
    logic [LIFT_IDX_W-1:0] idx_next;
    logic [K1_OUT_W-1:0]   t2_k1_reg;
    lcbs_item_t            t2_item_reg;
    logic                  res_v_reg;
    lcbs_result_t          res_reg;
    lcbs_result_t          res_next;
    logic [ZC_W-1:0]       zc;

    // Bits per block: the whole block for a single block, else ceil(b / C) + CRC.
    assign k1_next = in_item.single ? DIV_W'(in_item.tb_bits)
                                    : in_quo + DIV_W'(CB_CRC_LEN);

    // Compare K1 against Kb times every lifting size; the result is a thermometer.
    always_comb
    begin
        for (int i = 0; i < LIFT_COUNT; i++)
        begin
            ge_next[i] = (DIV_W'(k_item_reg.kb) * DIV_W'(LIFT_SIZE[i])) >= k1_reg;
        end
    end

    // First entry that fits; the largest one when none does.
    always_comb
    begin
        idx_next = LIFT_LAST;
        for (int i = LIFT_COUNT - 1; i >= 0; i--)
        begin
            if (ge_reg[i])
            begin
                idx_next = LIFT_IDX_W'(i);
            end
        end
    end

    // Table lookup and the result word.
    always_comb
    begin
        zc = LIFT_SIZE[idx_reg];
        res_next.base_graph     = t2_item_reg.bg2;
        res_next.num_blocks     = t2_item_reg.c_sat;
        res_next.bits_per_block = t2_k1_reg;
        res_next.crc_bits       = t2_item_reg.single ? CRC_BITS_NONE : CRC_BITS_MULTI;
        res_next.lifting_size   = zc;
        res_next.lift_set       = LIFT_SET[idx_reg];
        // 10*Zc for graph 2, 22*Zc for graph 1.
        if (t2_item_reg.bg2)
        begin
            res_next.block_size = BS_W'({zc, 3'b000}) + BS_W'({zc, 1'b0});
        end
        else
        begin
            res_next.block_size = BS_W'({zc, 4'b0000}) + BS_W'({zc, 2'b00})
                                  + BS_W'({zc, 1'b0});
        end
        res_next.size_error     = t2_item_reg.size_err;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_v_reg   <= 1'b0;
            t1_v_reg  <= 1'b0;
            t2_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else if (en)
        begin
            k_v_reg   <= in_valid;
            t1_v_reg  <= k_v_reg;
            t2_v_reg  <= t1_v_reg;
            res_v_reg <= t2_v_reg;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg      <= k1_next;
            k_item_reg  <= in_item;
            ge_reg      <= ge_next;
            t1_k1_reg   <= k1_reg[K1_OUT_W-1:0];
            t1_item_reg <= k_item_reg;
            idx_reg     <= idx_next;
            t2_k1_reg   <= t1_k1_reg;
            t2_item_reg <= t1_item_reg;
            res_reg     <= res_next;
        end
    end

    assign out_valid = res_v_reg;
    assign out_res   = res_reg;

endmodule

[sv/lcbs_out_buf.sv]
module lcbs_out_buf
    import lcbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  lcbs_result_t in_res,
    output logic         full,
    lcbs_out_if.source   seg_out
);

    // Two-entry queue that lets the pipeline run while a result waits.
    lcbs_result_t mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         push;
    logic         pop;
    lcbs_result_t head;

    assign full = count_reg == 2'd2;
    assign push = in_valid && !full;
    assign pop  = seg_out.valid && seg_out.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_res;
        end
    end

    // Head of the queue drives the channel.
    assign head                   = mem_reg[rd_ptr_reg];
    assign seg_out.valid          = count_reg != 2'd0;
    assign seg_out.base_graph     = head.base_graph;
    assign seg_out.num_blocks     = head.num_blocks;
    assign seg_out.bits_per_block = head.bits_per_block;
    assign seg_out.crc_bits       = head.crc_bits;
    assign seg_out.lifting_size   = head.lifting_size;
    assign seg_out.lift_set       = head.lift_set;
    assign seg_out.block_size     = head.block_size;
    assign seg_out.size_error     = head.size_error;

endmodule

[sv/ldpc_code_block_segmentation_params.sv]
// Channel   Role  Word                              Handshake
// tb_in     sink  tb_bits, rate_q10                 valid / ready
// seg_out   src   base_graph .. size_error (8)      valid / ready
// apb       cfg   max_block_bg1 @0, max_block_bg2 @4 psel / penable, pready = 1
//
// One word is accepted every cycle while the output queue has room.
// Most of the pipeline stages belong to the two restoring dividers, one quotient bit per stage.
// Reset clears all valid bits and the output queue; no clearing pass is needed.
// When the two-entry output queue is full the whole pipeline holds and tb_in.ready
// drops; nothing is lost or repeated.
module ldpc_code_block_segmentation_params
    import lcbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lcbs_in_if.sink            tb_in,
    lcbs_out_if.source         seg_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [BG1_W-1:0] max_bg1_reg;
    logic [BG2_W-1:0] max_bg2_reg;
    logic             cfg_write;
    lcbs_reg_t        reg_sel;

    logic             pipe_en;
    logic             full;

    logic             fr_valid;
    logic [DIV_W-1:0] fr_num;
    logic [DIV_W-1:0] fr_den;
    lcbs_item_t       fr_item;

    logic             d1_valid;
    logic [DIV_W-1:0] d1_quo;
    lcbs_item_t       d1_item;

    logic             m_v_reg;
    logic [DIV_W-1:0] m_num_reg;
    logic [DIV_W-1:0] m_num_next;
    logic [DIV_W-1:0] m_den_reg;
    logic [DIV_W-1:0] m_den_next;
    lcbs_item_t       m_item_reg;
    lcbs_item_t       m_item_next;

    logic             d2_valid;
    logic [DIV_W-1:0] d2_quo;
    lcbs_item_t       d2_item;

    logic             lf_valid;
    lcbs_result_t     lf_res;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_sel   = lcbs_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bg1_reg <= MAX_BG1_RESET;
            max_bg2_reg <= MAX_BG2_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_MAX_BG1: max_bg1_reg <= pwdata[BG1_W-1:0];
                REG_MAX_BG2: max_bg2_reg <= pwdata[BG2_W-1:0];
                default:     max_bg1_reg <= max_bg1_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MAX_BG1: prdata = 32'(max_bg1_reg);
            REG_MAX_BG2: prdata = 32'(max_bg2_reg);
            default:     prdata = '0;
        endcase
    end

    // The pipeline advances whenever the output queue has room.
    assign pipe_en     = !full;
    assign tb_in.ready = pipe_en;

    lcbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (tb_in.valid),
        .tb_bits  (tb_in.tb_bits),
        .rate_q10 (tb_in.rate_q10),
        .max_bg1  (max_bg1_reg),
        .max_bg2  (max_bg2_reg),
        .out_valid(fr_valid),
        .out_num  (fr_num),
        .out_den  (fr_den),
        .out_item (fr_item)
    );

    // Block count C = ceil(b / (Kcb - 24)).
    lcbs_div u_div_blocks (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (fr_valid),
        .in_num   (fr_num),
        .in_den   (fr_den),
        .in_item  (fr_item),
        .out_valid(d1_valid),
        .out_quo  (d1_quo),
        .out_item (d1_item)
    );

    // Saturated count and the operands of ceil(b / C).
    always_comb
    begin
        m_den_next  = d1_item.single ? DIV_W'(1) : d1_quo;
        m_num_next  = DIV_W'(d1_item.tb_bits) + m_den_next - DIV_W'(1);
        m_item_next = d1_item;
        if (m_den_next > DIV_W'(NUM_BLOCKS_MAX))
        begin
            m_item_next.c_sat = NUM_BLOCKS_MAX;
        end
        else
        begin
            m_item_next.c_sat = m_den_next[NB_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            m_v_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m_num_reg  <= m_num_next;
            m_den_reg  <= m_den_next;
            m_item_reg <= m_item_next;
        end
    end

    // Bits per block before the CRC: ceil(b / C).
    lcbs_div u_div_bits (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (m_v_reg),
        .in_num   (m_num_reg),
        .in_den   (m_den_reg),
        .in_item  (m_item_reg),
        .out_valid(d2_valid),
        .out_quo  (d2_quo),
        .out_item (d2_item)
    );

    lcbs_lift u_lift (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (d2_valid),
        .in_quo   (d2_quo),
        .in_item  (d2_item),
        .out_valid(lf_valid),
        .out_res  (lf_res)
    );

    lcbs_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(lf_valid),
        .in_res  (lf_res),
        .full    (full),
        .seg_out (seg_out)
    );

`ifndef SYNTHESIS
    // A result without block CRC always describes a single block.
    a_single_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
        seg_out.valid && (seg_out.crc_bits == CRC_BITS_NONE) |->
        (seg_out.num_blocks == NB_W'(1)))
        else $error("single block result with wrong block count");

    // Several blocks always carry a block CRC.
    a_multi_crc: assert property (@(posedge clk) disable iff (!rst_n)
        seg_out.valid && (seg_out.num_blocks > NB_W'(1)) |->
        (seg_out.crc_bits == CRC_BITS_MULTI))
        else $error("multi block result without block CRC");

    // A write to the graph 1 limit lands in the register on the next cycle.
    a_cfg_bg1: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (reg_sel == REG_MAX_BG1) |=>
        (max_bg1_reg == $past(pwdata[BG1_W-1:0])))
        else $error("graph 1 limit write lost");
`endif

endmodule
